>>> hdl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and helpers for the template tag scanner.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int POS_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int TYPE_W    = 3;
    localparam int CFG_W     = 48;
    localparam int TAG_KINDS = 6;
    localparam int SLOTS     = 6;

    localparam logic [POS_W-1:0] MAX_LEN = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_OPEN_LEAD   = 2'd0;
    localparam logic [1:0] CFG_OPEN_SECOND = 2'd1;
    localparam logic [1:0] CFG_CLOSE_FIRST = 2'd2;
    localparam logic [1:0] CFG_CLOSE_SECND = 2'd3;

    // reset table: keys { % ( - ^ <, closers }} %} )} -} ^} >}
    localparam logic [BYTE_W-1:0] RST_OPEN_LEAD   = 8'h7B;
    localparam logic [CFG_W-1:0]  RST_OPEN_SECOND = 48'h3C5E2D28257B;
    localparam logic [CFG_W-1:0]  RST_CLOSE_FIRST = 48'h3E5E2D29257D;
    localparam logic [CFG_W-1:0]  RST_CLOSE_SECND = 48'h7D7D7D7D7D7D;

    // result kinds
    localparam logic RK_TAG = 1'b0;
    localparam logic RK_END = 1'b1;

    typedef struct packed {
        logic              result_kind;
        logic [POS_W-1:0]  text_start;
        logic [POS_W-1:0]  tag_start;
        logic [POS_W-1:0]  tag_end;
        logic [TYPE_W-1:0] tag_type;
        logic              length_overflow;
        logic              last_of_run;
    } t_result;

    // up to two results produced by one transfer
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // table slot k; bit 8 set means "matches no byte"
    function automatic logic [BYTE_W:0] slot_byte(input logic [CFG_W-1:0]  packed_tbl,
                                                  input logic [TYPE_W-1:0] k);
        logic [BYTE_W:0] v;
        v = {1'b1, {BYTE_W{1'b0}}};
        for (int s = 0; s < SLOTS; s++) begin
            if (k == TYPE_W'(s)) begin
                v = {1'b0, packed_tbl[s*BYTE_W +: BYTE_W]};
            end
        end
        return v;
    endfunction

endpackage

>>> hdl/tts_in_if.sv
// ----------------------------------------------------------------------------
// tts_in_if
// Text byte channel: valid/ready with one byte and an end-of-text flag.
// ----------------------------------------------------------------------------
interface tts_in_if;
    logic                       valid;
    logic                       ready;
    logic [tts_pkg::BYTE_W-1:0] text_byte;
    logic                       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> hdl/tts_out_if.sv
// ----------------------------------------------------------------------------
// tts_out_if
// Result channel: valid/ready with one tag or end-of-string result.
// ----------------------------------------------------------------------------
interface tts_out_if;
    logic                       valid;
    logic                       ready;
    logic                       result_kind;
    logic [tts_pkg::POS_W-1:0]  text_start;
    logic [tts_pkg::POS_W-1:0]  tag_start;
    logic [tts_pkg::POS_W-1:0]  tag_end;
    logic [tts_pkg::TYPE_W-1:0] tag_type;
    logic                       length_overflow;
    logic                       last_of_run;

    modport source (output valid, output result_kind, output text_start, output tag_start,
                    output tag_end, output tag_type, output length_overflow,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input text_start, input tag_start,
                    input tag_end, input tag_type, input length_overflow,
                    input last_of_run, output ready);
endinterface

>>> hdl/template_tag_scanner_unit.sv
// ----------------------------------------------------------------------------
// template_tag_scanner_unit
// Scans a byte stream for template tags and reports tag and end results.
// ----------------------------------------------------------------------------
// Usage:
//  - i_text carries one nonzero text byte per transfer, end_of_text on the
//    last byte of a string. o_result carries one result per transfer.
//  - A byte is scanned in the cycle it transfers; its results (none, one
//    or two) sit in a four-entry result queue and show on o_result from
//    the next cycle on.
//  - Throughput is one byte per cycle. i_text.ready drops only when the
//    queue holds three or more results, since one byte may add two (a
//    tag closing on the last byte of a string).
//  - When the receiver stalls, results wait in the queue and input keeps
//    flowing until the queue is nearly full.
//  - Reset (synchronous, active low) restores the default tag table,
//    clears scan state and empties the queue. After an end result the scan
//    state returns to its reset values; the table is kept.
//  - The table is written through i_cfg_we / i_cfg_index / i_cfg_data;
//    write it only while the block is idle (the block does not check).
// ----------------------------------------------------------------------------
module template_tag_scanner_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tts_pkg::CFG_W-1:0]   i_cfg_data,
    tts_in_if.sink                      i_text,
    tts_out_if.source                   o_result
);

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_LEAD   = 2'd1,
        MODE_TAG    = 2'd2,
        MODE_CLOSE1 = 2'd3
    } t_mode;

    // tag table
    logic [tts_pkg::BYTE_W-1:0] r_open_lead;
    logic [tts_pkg::CFG_W-1:0]  r_open_second;
    logic [tts_pkg::CFG_W-1:0]  r_close_first;
    logic [tts_pkg::CFG_W-1:0]  r_close_secnd;

    // scan state
    t_mode                      r_mode,       n_mode;
    logic [tts_pkg::TYPE_W-1:0] r_type,       n_type;
    logic [tts_pkg::POS_W-1:0]  r_pos,        n_pos;
    logic [tts_pkg::POS_W-1:0]  r_text_begin, n_text_begin;
    logic [tts_pkg::POS_W-1:0]  r_lead_pos,   n_lead_pos;
    logic                       r_ovf,        n_ovf;

    logic                       accept;
    logic                       room;
    logic [tts_pkg::BYTE_W:0]   b9;
    logic                       key_hit;
    logic [tts_pkg::TYPE_W-1:0] key_idx;
    logic                       tag_hit;
    logic                       fin;
    tts_pkg::t_result           tag_res;
    tts_pkg::t_result           end_res;
    tts_pkg::t_push             push;
    tts_pkg::t_result           head;

    assign i_text.ready = room;
    assign accept       = i_text.valid && room;
    assign fin          = i_text.end_of_text;
    assign b9           = {1'b0, i_text.text_byte};

    // key lookup: lowest matching entry wins
    always_comb begin
        key_hit = 1'b0;
        key_idx = '0;
        for (int k = tts_pkg::TAG_KINDS - 1; k >= 0; k--) begin
            if (k < tts_pkg::SLOTS &&
                b9 == tts_pkg::slot_byte(r_open_second, tts_pkg::TYPE_W'(k))) begin
                key_hit = 1'b1;
                key_idx = tts_pkg::TYPE_W'(k);
            end
        end
    end

    // per-byte scan step
    always_comb begin
        n_mode       = r_mode;
        n_type       = r_type;
        n_lead_pos   = r_lead_pos;
        n_text_begin = r_text_begin;
        tag_hit      = 1'b0;

        // position saturates at MAX_LEN and flags overflow
        if (r_pos == tts_pkg::MAX_LEN) begin
            n_pos = r_pos;
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            n_ovf = r_ovf;
        end

        unique case (r_mode)
            MODE_PLAIN: begin
                if (i_text.text_byte == r_open_lead) begin
                    n_lead_pos = r_pos;
                    n_mode     = MODE_LEAD;
                end
            end
            MODE_LEAD: begin
                if (key_hit) begin
                    n_type = key_idx;
                    n_mode = MODE_TAG;
                end else if (i_text.text_byte == r_open_lead) begin
                    n_lead_pos = r_pos;   // retry as a new lead byte
                end else begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_TAG: begin
                if (b9 == tts_pkg::slot_byte(r_close_first, r_type)) begin
                    n_mode = MODE_CLOSE1;
                end
            end
            MODE_CLOSE1: begin
                if (b9 == tts_pkg::slot_byte(r_close_secnd, r_type)) begin
                    tag_hit = 1'b1;
                end else if (b9 != tts_pkg::slot_byte(r_close_first, r_type)) begin
                    n_mode = MODE_TAG;
                end
            end
            default: n_mode = MODE_PLAIN;
        endcase

        tag_res.result_kind     = tts_pkg::RK_TAG;
        tag_res.text_start      = r_text_begin;
        tag_res.tag_start       = r_lead_pos;
        tag_res.tag_end         = r_pos;
        tag_res.tag_type        = r_type;
        tag_res.length_overflow = 1'b0;
        tag_res.last_of_run     = !fin;

        if (tag_hit) begin
            n_text_begin = n_pos;
            n_mode       = MODE_PLAIN;
        end

        end_res.result_kind     = tts_pkg::RK_END;
        end_res.text_start      = n_text_begin;
        end_res.tag_start       = '0;
        end_res.tag_end         = '0;
        end_res.tag_type        = '0;
        end_res.length_overflow = n_ovf;
        end_res.last_of_run     = 1'b1;

        // end of string: scan state back to reset values
        if (fin) begin
            n_mode       = MODE_PLAIN;
            n_type       = '0;
            n_pos        = '0;
            n_text_begin = '0;
            n_lead_pos   = '0;
            n_ovf        = 1'b0;
        end

        push.count  = 2'd0;
        push.first  = tag_hit ? tag_res : end_res;
        push.second = end_res;
        if (accept) begin
            push.count = {1'b0, tag_hit} + {1'b0, fin};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_lead   <= tts_pkg::RST_OPEN_LEAD;
            r_open_second <= tts_pkg::RST_OPEN_SECOND;
            r_close_first <= tts_pkg::RST_CLOSE_FIRST;
            r_close_secnd <= tts_pkg::RST_CLOSE_SECND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tts_pkg::CFG_OPEN_LEAD:   r_open_lead <= i_cfg_data[tts_pkg::BYTE_W-1:0];
                tts_pkg::CFG_OPEN_SECOND: r_open_second <= i_cfg_data;
                tts_pkg::CFG_CLOSE_FIRST: r_close_first <= i_cfg_data;
                tts_pkg::CFG_CLOSE_SECND: r_close_secnd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PLAIN;
            r_type       <= '0;
            r_pos        <= '0;
            r_text_begin <= '0;
            r_lead_pos   <= '0;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_type       <= n_type;
            r_pos        <= n_pos;
            r_text_begin <= n_text_begin;
            r_lead_pos   <= n_lead_pos;
            r_ovf        <= n_ovf;
        end
    end

    tts_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (head)
    );

    assign o_result.result_kind     = head.result_kind;
    assign o_result.text_start      = head.text_start;
    assign o_result.tag_start       = head.tag_start;
    assign o_result.tag_end         = head.tag_end;
    assign o_result.tag_type        = head.tag_type;
    assign o_result.length_overflow = head.length_overflow;
    assign o_result.last_of_run     = head.last_of_run;

endmodule

>>> hdl/tts_result_fifo.sv
// ----------------------------------------------------------------------------
// tts_result_fifo
// Four-entry result queue; takes up to two results per cycle, gives one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module tts_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tts_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output tts_pkg::t_result o_data
);

    tts_pkg::t_result r_mem [4];
    logic [1:0]       r_wr;
    logic [1:0]       r_rd;
    logic [2:0]       r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a worst-case pair of results
    assign o_room  = (r_cnt < 3'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr  <= r_wr + i_push.count;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push.count} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.second;
        end
    end

endmodule

>>> tb/template_tag_scanner_unit_checker.sv
// ----------------------------------------------------------------------------
// template_tag_scanner_unit_checker
// Watches the text and result channels, predicts the tag and end results from
// its own copy of the tag table and scan state, and compares every result
// transfer field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module template_tag_scanner_unit_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tts_pkg::CFG_W-1:0]   i_cfg_data,
    tts_in_if                           i_text,
    tts_out_if                          i_result,
    output int                          o_pending,
    output int                          o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_LEAD,
        MODE_TAG,
        MODE_CLOSE1
    } t_scan_mode;

    // tag table copy
    logic [BYTE_W-1:0] lead_byte;
    logic [CFG_W-1:0]  key_bytes;
    logic [CFG_W-1:0]  close1_bytes;
    logic [CFG_W-1:0]  close2_bytes;

    // scan state copy
    t_scan_mode        mode;
    logic [TYPE_W-1:0] open_kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  text_from;
    logic [POS_W-1:0]  lead_pos;
    logic              ovf;

    t_result results_due[$];
    int      mismatch_total = 0;

    function automatic logic [BYTE_W-1:0] slot_of(input logic [CFG_W-1:0] tbl,
                                                  input logic [TYPE_W-1:0] k);
        return tbl[int'(k)*BYTE_W +: BYTE_W];
    endfunction

    task automatic clear_scan();
        mode      = MODE_PLAIN;
        open_kind = '0;
        pos       = '0;
        text_from = '0;
        lead_pos  = '0;
        ovf       = 1'b0;
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] nxt;
        logic             closed;
        int               hit;
        t_result          r;
        p      = pos;
        closed = 1'b0;
        hit    = -1;
        // counter saturates at MAX_LEN; any byte landing there marks overflow
        if (p != MAX_LEN) begin
            nxt = p + 1'b1;
        end else begin
            nxt = MAX_LEN;
            ovf = 1'b1;
        end
        // lowest matching key wins
        for (int k = TAG_KINDS - 1; k >= 0; k--) begin
            if (k < SLOTS && key_bytes[k*BYTE_W +: BYTE_W] == b) hit = k;
        end
        case (mode)
            MODE_PLAIN: begin
                if (b == lead_byte) begin
                    lead_pos = p;
                    mode     = MODE_LEAD;
                end
            end
            MODE_LEAD: begin
                if (hit >= 0) begin
                    open_kind = TYPE_W'(hit);
                    mode      = MODE_TAG;
                end else if (b == lead_byte) begin
                    lead_pos = p;
                end else begin
                    mode = MODE_PLAIN;
                end
            end
            MODE_TAG: begin
                if (b == slot_of(close1_bytes, open_kind)) mode = MODE_CLOSE1;
            end
            default: begin
                // a failed second closer byte may still be a first closer byte
                if (b == slot_of(close2_bytes, open_kind)) begin
                    closed = 1'b1;
                end else if (b != slot_of(close1_bytes, open_kind)) begin
                    mode = MODE_TAG;
                end
            end
        endcase
        if (closed) begin
            r = '{result_kind: RK_TAG, text_start: text_from, tag_start: lead_pos,
                  tag_end: p, tag_type: open_kind, length_overflow: 1'b0,
                  last_of_run: !fin};
            results_due.push_back(r);
            text_from = nxt;
            mode      = MODE_PLAIN;
        end
        pos = nxt;
        if (fin) begin
            r = '{result_kind: RK_END, text_start: text_from, tag_start: '0,
                  tag_end: '0, tag_type: '0, length_overflow: ovf, last_of_run: 1'b1};
            results_due.push_back(r);
            clear_scan();
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (results_due.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= 10) begin
                $display("unexpected result: kind=%0d text=%0d tag=%0d..%0d type=%0d ovf=%0d last=%0d",
                         got.result_kind, got.text_start, got.tag_start, got.tag_end,
                         got.tag_type, got.length_overflow, got.last_of_run);
            end
        end else begin
            want = results_due.pop_front();
            if (got.result_kind !== want.result_kind || got.text_start !== want.text_start ||
                got.tag_start !== want.tag_start || got.tag_end !== want.tag_end ||
                got.tag_type !== want.tag_type ||
                got.length_overflow !== want.length_overflow ||
                got.last_of_run !== want.last_of_run) begin
                mismatch_total++;
                if (mismatch_total <= 10) begin
                    $display("mismatch: exp kind=%0d text=%0d tag=%0d..%0d type=%0d ovf=%0d last=%0d",
                             want.result_kind, want.text_start, want.tag_start, want.tag_end,
                             want.tag_type, want.length_overflow, want.last_of_run);
                    $display("          got kind=%0d text=%0d tag=%0d..%0d type=%0d ovf=%0d last=%0d",
                             got.result_kind, got.text_start, got.tag_start, got.tag_end,
                             got.tag_type, got.length_overflow, got.last_of_run);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lead_byte    = RST_OPEN_LEAD;
            key_bytes    = RST_OPEN_SECOND;
            close1_bytes = RST_CLOSE_FIRST;
            close2_bytes = RST_CLOSE_SECND;
            clear_scan();
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OPEN_LEAD:   lead_byte    = i_cfg_data[BYTE_W-1:0];
                    CFG_OPEN_SECOND: key_bytes    = i_cfg_data;
                    CFG_CLOSE_FIRST: close1_bytes = i_cfg_data;
                    CFG_CLOSE_SECND: close2_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_text.valid === 1'b1 && i_text.ready === 1'b1) begin
                scan_byte(i_text.text_byte, i_text.end_of_text);
            end
            if (i_result.valid === 1'b1 && i_result.ready === 1'b1) begin
                check_result('{result_kind: i_result.result_kind,
                               text_start: i_result.text_start,
                               tag_start: i_result.tag_start,
                               tag_end: i_result.tag_end,
                               tag_type: i_result.tag_type,
                               length_overflow: i_result.length_overflow,
                               last_of_run: i_result.last_of_run});
            end
        end
        o_pending    <= results_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

>>> tb/template_tag_scanner_unit_tb.sv
// ----------------------------------------------------------------------------
// template_tag_scanner_unit_tb
// Drives text strings into the tag scanner under several tag tables: a short
// directed string set, then random strings built mostly from well-formed tags
// with broken tags and noise mixed in. Both channels idle at random. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module template_tag_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int RUN_LIMIT = 200_000;     // watchdog limit, in cycles
    localparam int IDLE_PCT  = 23;
    localparam int SETTLE    = 4;           // slack after the last predicted result

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              no_idle;
    int                cycles = 0;
    int                pending;
    int                mismatches;
    int                bytes_sent = 0;

    logic [BYTE_W-1:0] text_q[$];

    // table currently loaded, so stimulus can aim at lead, key and closer bytes
    logic [BYTE_W-1:0] cur_lead;
    logic [CFG_W-1:0]  cur_keys;
    logic [CFG_W-1:0]  cur_close1;
    logic [CFG_W-1:0]  cur_close2;

    tts_in_if  txt_ch();
    tts_out_if res_ch();

    template_tag_scanner_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_text      (txt_ch),
        .o_result    (res_ch)
    );

    template_tag_scanner_unit_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_text       (txt_ch),
        .i_result     (res_ch),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: random back-pressure, none during the no-idle stretch
    always @(posedge i_clk) begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // zero is not a legal text byte; swap it for a random one
    function automatic logic [BYTE_W-1:0] nz(input logic [BYTE_W-1:0] b);
        return (b == '0) ? BYTE_W'($urandom_range(1, 255)) : b;
    endfunction

    // half the time a byte the table cares about, else anything
    function automatic logic [BYTE_W-1:0] any_byte();
        int k;
        k = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(1) == 0) return BYTE_W'($urandom_range(1, 255));
        case ($urandom_range(0, 3))
            0:       return nz(cur_lead);
            1:       return nz(cur_keys[k*BYTE_W +: BYTE_W]);
            2:       return nz(cur_close1[k*BYTE_W +: BYTE_W]);
            default: return nz(cur_close2[k*BYTE_W +: BYTE_W]);
        endcase
    endfunction

    // narrow alphabet so random tables get duplicate and shared bytes
    function automatic logic [BYTE_W-1:0] tbl_byte();
        if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(0, 255));
        return BYTE_W'(8'h21 + $urandom_range(0, 5));
    endfunction

    function automatic logic [CFG_W-1:0] rand_tbl();
        logic [CFG_W-1:0] t;
        for (int s = 0; s < SLOTS; s++) t[s*BYTE_W +: BYTE_W] = tbl_byte();
        return t;
    endfunction

    // one segment: well-formed tag, broken tag, or noise
    task automatic add_segment();
        int k;
        int r;
        k = $urandom_range(0, TAG_KINDS - 1);
        r = $urandom_range(99);
        if (r < 75) begin
            repeat ($urandom_range(0, 4)) text_q.push_back(any_byte());
            text_q.push_back(nz(cur_lead));
            text_q.push_back(nz(cur_keys[k*BYTE_W +: BYTE_W]));
            repeat ($urandom_range(0, 4)) text_q.push_back(any_byte());
            if (r < 60) begin
                text_q.push_back(nz(cur_close1[k*BYTE_W +: BYTE_W]));
                // doubled first closer byte: second copy must restart the closer
                if ($urandom_range(0, 4) == 0) begin
                    text_q.push_back(nz(cur_close1[k*BYTE_W +: BYTE_W]));
                end
                text_q.push_back(nz(cur_close2[k*BYTE_W +: BYTE_W]));
            end else if ($urandom_range(1) == 0) begin
                // closer cut short
                text_q.push_back(nz(cur_close1[k*BYTE_W +: BYTE_W]));
            end
        end else begin
            repeat ($urandom_range(1, 6)) text_q.push_back(any_byte());
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            txt_ch.valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < IDLE_PCT);
        end
        txt_ch.valid       <= 1'b1;
        txt_ch.text_byte   <= b;
        txt_ch.end_of_text <= fin;
        do begin
            @(posedge i_clk);
        end while (txt_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    // send the queued string, end flag on its last byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    task automatic queue_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            repeat ($urandom_range(1, 5)) add_segment();
            send_text();
        end
    endtask

    // stop sending, wait for every predicted result, then wait out the SETTLE slack
    task automatic settle();
        txt_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // writes all four registers on back-to-back cycles; block must be idle
    task automatic load_table(input logic [BYTE_W-1:0] lead, input logic [CFG_W-1:0] keys,
                              input logic [CFG_W-1:0] c1, input logic [CFG_W-1:0] c2);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OPEN_LEAD;
        cfg_data  <= CFG_W'(lead);
        @(posedge i_clk);
        cfg_index <= CFG_OPEN_SECOND;
        cfg_data  <= keys;
        @(posedge i_clk);
        cfg_index <= CFG_CLOSE_FIRST;
        cfg_data  <= c1;
        @(posedge i_clk);
        cfg_index <= CFG_CLOSE_SECND;
        cfg_data  <= c2;
        @(posedge i_clk);
        cfg_we     <= 1'b0;
        cur_lead   = lead;
        cur_keys   = keys;
        cur_close1 = c1;
        cur_close2 = c2;
    endtask

    initial begin
        txt_ch.valid       <= 1'b0;
        txt_ch.text_byte   <= '0;
        txt_ch.end_of_text <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_OPEN_LEAD;
        cfg_data           <= '0;
        no_idle            <= 1'b0;
        i_rst_n            <= 1'b0;
        cur_lead   = RST_OPEN_LEAD;
        cur_keys   = RST_OPEN_SECOND;
        cur_close1 = RST_CLOSE_FIRST;
        cur_close2 = RST_CLOSE_SECND;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, default table. First string: plain tag at position 0,
        // a first closer byte repeated before the second, a non-key after
        // the lead, and a tag closing on the final byte (tag plus end result).
        queue_str("{{}}a{%%%}");
        text_q.push_back(8'hFF);
        queue_str("{x");
        text_q.push_back(8'h01);
        queue_str("{(");
        text_q.push_back(8'h01);
        queue_str(")}");
        send_text();
        // string ending inside a closer: end result only
        queue_str("{^x^");
        send_text();
        // one-byte string
        text_q.push_back(8'h80);
        send_text();
        settle();

        run_random(500);
        settle();

        // low extremes: lead 1, no key can match, closers all ones / all zero
        load_table(8'h01, '0, '1, '0);
        run_random(100);
        settle();

        // high extremes: every table byte equal to the lead
        load_table(8'hFF, '1, '1, '1);
        run_random(200);
        settle();

        // random tables; the first one runs with no idling on either side
        no_idle <= 1'b1;
        load_table(nz(tbl_byte()), rand_tbl(), rand_tbl(), rand_tbl());
        run_random(300);
        settle();
        no_idle <= 1'b0;
        repeat (2) begin
            load_table(nz(tbl_byte()), rand_tbl(), rand_tbl(), rand_tbl());
            run_random(300);
            settle();
        end

        // back to the default table, then more short strings
        load_table(RST_OPEN_LEAD, RST_OPEN_SECOND, RST_CLOSE_FIRST, RST_CLOSE_SECND);
        run_random(250);
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
